@@ src/iba_pkg.sv @@
`timescale 1ns / 1ps
// Package for the indexed block allocator.
// Holds the item and result codes and the internal item type; no dependencies.
package iba_pkg;

	localparam int unsigned BLK_W = 7;
	localparam int unsigned LEN_W = 7;

	typedef enum logic [0:0] {
		OP_START = 1'b0,
		OP_DATA  = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		ST_PENDING   = 3'd0,
		ST_COMMITTED = 3'd1,
		ST_RANGE     = 3'd2,
		ST_TAKEN     = 3'd3,
		ST_TOO_MANY  = 3'd4,
		ST_IGNORED   = 3'd5
	} status_t;

	typedef struct packed {
		logic             opcode;
		logic [BLK_W-1:0] block_number;
		logic             last_block;
	} item_t;

endpackage

@@ src/iba_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channels of the indexed block allocator: request items and results.
// Depends on iba_pkg for field widths.
interface iba_item_if;
	logic                        valid;
	logic                        ready;
	logic                        opcode;
	logic [iba_pkg::BLK_W-1:0]   block_number;
	logic                        last_block;

	modport source (output valid, output opcode, output block_number, output last_block,
		input ready);
	modport sink (input valid, input opcode, input block_number, input last_block,
		output ready);
endinterface

interface iba_result_if;
	logic                        valid;
	logic                        ready;
	logic [2:0]                  status;
	logic [iba_pkg::LEN_W-1:0]   request_length;

	modport source (output valid, output status, output request_length, input ready);
	modport sink (input valid, input status, input request_length, output ready);
endinterface

@@ src/indexed_block_allocator.sv @@
`timescale 1ns / 1ps
// Indexed block allocator: allocation bitmap with two-phase file requests.
// Each accepted item passes the input register, then the result register, which holds its result.
// Throughput: one item per cycle; input stalls only while the result register is held.
// Checks and bitmap updates are computed combinationally between the two registers.
// Reset (arst_n low) frees every block and closes any open request at once.
module indexed_block_allocator #(
	parameter int unsigned DISK_SIZE = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	iba_item_if.sink     in_ch,
	iba_result_if.source out_ch
);

	logic           advance;
	logic           valid_s1;
	iba_pkg::item_t item_s1;

	iba_input_reg u_input_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	iba_alloc_core #(
		.DISK_SIZE (DISK_SIZE)
	) u_alloc_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.advance  (advance),
		.out_ch   (out_ch)
	);

endmodule

@@ src/iba_input_reg.sv @@
`timescale 1ns / 1ps
// Input register stage of the indexed block allocator.
// Depends on iba_pkg and iba_item_if.
module iba_input_reg (
	input  logic             clk,
	input  logic             arst_n,
	iba_item_if.sink         in_ch,
	input  logic             advance,
	output logic             valid_s1,
	output iba_pkg::item_t   item_s1
);

	logic v_s1;

	assign in_ch.ready = !v_s1 || advance;
	assign valid_s1    = v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	// hold payload while stalled
	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			item_s1.opcode       <= in_ch.opcode;
			item_s1.block_number <= in_ch.block_number;
			item_s1.last_block   <= in_ch.last_block;
		end
	end

endmodule

@@ src/iba_alloc_core.sv @@
`timescale 1ns / 1ps
// Allocation state, per-item checks and result register of the allocator.
// Depends on iba_pkg and iba_result_if.
module iba_alloc_core #(
	parameter int unsigned DISK_SIZE = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  iba_pkg::item_t   item_s1,
	output logic             advance,
	iba_result_if.source     out_ch
);

	localparam int unsigned IDX_W = $clog2(DISK_SIZE);
	localparam int unsigned CNT_W = $clog2(DISK_SIZE + 1);

	logic [DISK_SIZE-1:0] allocated_q, pending_q;
	logic [IDX_W-1:0]     held_q;
	logic                 open_q, failed_q;
	logic [CNT_W-1:0]     count_q;

	logic [DISK_SIZE-1:0] allocated_d, pending_d, blk_oh;
	logic [IDX_W-1:0]     held_d, blk_idx;
	logic                 open_d, failed_d, in_range, hit;
	logic [CNT_W-1:0]     count_d;
	iba_pkg::status_t     status_d;

	logic                       out_v_q;
	iba_pkg::status_t           status_q;
	logic [iba_pkg::LEN_W-1:0]  len_q;

	assign advance = !out_v_q || out_ch.ready;

	assign in_range = item_s1.block_number < iba_pkg::BLK_W'(DISK_SIZE);
	assign blk_idx  = item_s1.block_number[IDX_W-1:0];
	assign blk_oh   = in_range ? (DISK_SIZE'(1) << blk_idx) : '0;
	assign hit      = |(allocated_q & blk_oh);

	always_comb begin
		allocated_d = allocated_q;
		pending_d   = pending_q;
		held_d      = held_q;
		open_d      = open_q;
		failed_d    = failed_q;
		count_d     = count_q;
		status_d    = iba_pkg::ST_IGNORED;
		if (item_s1.opcode == iba_pkg::OP_START) begin
			pending_d = '0;
			count_d   = '0;
			open_d    = 1'b1;
			failed_d  = 1'b0;
			if (!in_range) begin
				status_d = iba_pkg::ST_RANGE;
				failed_d = 1'b1;
			end else if (hit) begin
				status_d = iba_pkg::ST_TAKEN;
				failed_d = 1'b1;
			end else begin
				status_d  = iba_pkg::ST_PENDING;
				held_d    = blk_idx;
				pending_d = blk_oh;
			end
		end else if (!open_q) begin
			status_d = iba_pkg::ST_IGNORED;
		end else if (failed_q) begin
			status_d = iba_pkg::ST_IGNORED;
			if (item_s1.last_block) begin
				open_d    = 1'b0;
				failed_d  = 1'b0;
				pending_d = '0;
			end
		end else begin
			if (count_q >= CNT_W'(DISK_SIZE)) begin
				status_d = iba_pkg::ST_TOO_MANY;
			end else if (!in_range) begin
				status_d = iba_pkg::ST_RANGE;
			end else if (hit || item_s1.block_number == iba_pkg::BLK_W'(held_q)) begin
				status_d = iba_pkg::ST_TAKEN;
			end else begin
				status_d = iba_pkg::ST_PENDING;
			end
			if (status_d == iba_pkg::ST_PENDING) begin
				count_d   = count_q + CNT_W'(1);
				pending_d = pending_q | blk_oh;
				if (item_s1.last_block) begin
					allocated_d = allocated_q | pending_d;
					open_d      = 1'b0;
					failed_d    = 1'b0;
					pending_d   = '0;
					status_d    = iba_pkg::ST_COMMITTED;
				end
			end else begin
				pending_d = '0;
				failed_d  = 1'b1;
				if (item_s1.last_block) begin
					open_d   = 1'b0;
					failed_d = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allocated_q <= '0;
			pending_q   <= '0;
			held_q      <= '0;
			open_q      <= 1'b0;
			failed_q    <= 1'b0;
			count_q     <= '0;
			out_v_q     <= 1'b0;
		end else if (advance) begin
			out_v_q <= valid_s1;
			if (valid_s1) begin
				allocated_q <= allocated_d;
				pending_q   <= pending_d;
				held_q      <= held_d;
				open_q      <= open_d;
				failed_q    <= failed_d;
				count_q     <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			status_q <= status_d;
			len_q    <= iba_pkg::LEN_W'(count_d);
		end
	end

	assign out_ch.valid          = out_v_q;
	assign out_ch.status         = status_q;
	assign out_ch.request_length = len_q;

	a_pending_free: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q & allocated_q) == '0)
		else $error("pending block already allocated");

	a_alloc_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((allocated_q & $past(allocated_q)) == $past(allocated_q)))
		else $error("allocated block freed");

	a_failed_open: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q |-> (open_q && pending_q == '0))
		else $error("failed request not open or holds pending blocks");

	a_commit_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && status_q == iba_pkg::ST_COMMITTED) |-> (len_q != '0))
		else $error("commit with empty request");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DISK_SIZE))
		else $error("data count beyond disk size");

endmodule

@@ bench/alloc_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the indexed block allocator: watches both channels, predicts every result
// from its own copy of the bitmaps and request state, and compares results in order.
// Depends on iba_pkg and the channel interfaces of iba_if.sv.
module alloc_checker #(
	parameter int unsigned DISK_SIZE = 64
) (
	input  logic  clk,
	input  logic  arst_n,
	iba_item_if   item_ch,
	iba_result_if result_ch,
	output int    fail_count,
	output int    backlog
);

	typedef struct packed {
		iba_pkg::status_t          status;
		logic [iba_pkg::LEN_W-1:0] length;
	} alloc_result_t;

	logic [63:0]               allocated_map;
	logic [63:0]               pending_map;
	logic [5:0]                index_block;
	logic                      req_open;
	logic                      req_failed;
	logic [iba_pkg::LEN_W-1:0] data_count;
	alloc_result_t             expected_q[$];
	alloc_result_t             want;
	iba_pkg::item_t            seen;
	int                        mismatches;

	function automatic alloc_result_t predict_allocation(iba_pkg::item_t it);
		logic [63:0]      bit_mask;
		iba_pkg::status_t st;
		bit_mask = 64'd1 << it.block_number[5:0];
		if (it.opcode == iba_pkg::OP_START) begin
			pending_map = '0;
			data_count  = '0;
			req_open    = 1'b1;
			req_failed  = 1'b0;
			if (it.block_number >= DISK_SIZE) begin
				st = iba_pkg::ST_RANGE;
				req_failed = 1'b1;
			end else if ((allocated_map & bit_mask) != '0) begin
				st = iba_pkg::ST_TAKEN;
				req_failed = 1'b1;
			end else begin
				st = iba_pkg::ST_PENDING;
				index_block = it.block_number[5:0];
				pending_map = bit_mask;
			end
		end else if (!req_open || req_failed) begin
			st = iba_pkg::ST_IGNORED;
			if (req_open && it.last_block) begin
				req_open    = 1'b0;
				req_failed  = 1'b0;
				pending_map = '0;
			end
		end else begin
			if (data_count >= DISK_SIZE)
				st = iba_pkg::ST_TOO_MANY;
			else if (it.block_number >= DISK_SIZE)
				st = iba_pkg::ST_RANGE;
			else if ((allocated_map & bit_mask) != '0 || it.block_number[5:0] == index_block)
				st = iba_pkg::ST_TAKEN;
			else
				st = iba_pkg::ST_PENDING;

			if (st == iba_pkg::ST_PENDING) begin
				data_count  = data_count + 1'b1;
				pending_map = pending_map | bit_mask;
				if (it.last_block) begin
					allocated_map = allocated_map | pending_map;
					st = iba_pkg::ST_COMMITTED;
				end
			end else begin
				pending_map = '0;
				req_failed  = 1'b1;
			end
			if (it.last_block) begin
				req_open    = 1'b0;
				req_failed  = 1'b0;
				pending_map = '0;
			end
		end
		return '{status: st, length: data_count};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allocated_map = '0;
			pending_map   = '0;
			index_block   = '0;
			req_open      = 1'b0;
			req_failed    = 1'b0;
			data_count    = '0;
			mismatches    = 0;
			expected_q.delete();
			fail_count <= 0;
			backlog    <= 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_q.size() == 0) begin
					$display("%0t: expected no result, actual status %0d length %0d",
						$time, result_ch.status, result_ch.request_length);
					mismatches++;
				end else begin
					want = expected_q.pop_front();
					if (result_ch.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, result_ch.status);
						mismatches++;
					end
					if (result_ch.request_length !== want.length) begin
						$display("%0t: request_length expected %0d actual %0d",
							$time, want.length, result_ch.request_length);
						mismatches++;
					end
				end
			end
			if (item_ch.valid && item_ch.ready) begin
				seen = '{opcode: item_ch.opcode, block_number: item_ch.block_number,
					last_block: item_ch.last_block};
				expected_q.push_back(predict_allocation(seen));
			end
			fail_count <= mismatches;
			backlog    <= expected_q.size();
		end
	end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Top of the indexed block allocator bench: clock, reset, request items and result handshake.
// Depends on iba_pkg, iba_if.sv, indexed_block_allocator and alloc_checker.
module testbench;

	localparam int unsigned DISK_SIZE   = 64;
	localparam int          CYCLE_LIMIT = 200000;

	logic        clk = 1'b0;
	logic        arst_n;
	int          fail_count;
	int          backlog;
	int          sent;
	int          taken;
	int          cycle_count;
	logic [63:0] claimed;

	iba_item_if   req_ch ();
	iba_result_if res_ch ();

	indexed_block_allocator #(.DISK_SIZE(DISK_SIZE)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (req_ch),
		.out_ch (res_ch)
	);

	alloc_checker #(.DISK_SIZE(DISK_SIZE)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_ch    (req_ch),
		.result_ch  (res_ch),
		.fail_count (fail_count),
		.backlog    (backlog)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [iba_pkg::BLK_W-1:0] pick_free();
		int base;
		base = $urandom_range(0, DISK_SIZE - 1);
		for (int k = 0; k < DISK_SIZE; k++)
			if (!claimed[(base + k) % DISK_SIZE])
				return iba_pkg::BLK_W'((base + k) % DISK_SIZE);
		return iba_pkg::BLK_W'($urandom_range(0, 127));
	endfunction

	task automatic send_item(input iba_pkg::opcode_t op, input logic [iba_pkg::BLK_W-1:0] blk,
		input logic last);
		int gap;
		gap = ((sent / 40) % 3 == 0) ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.opcode       <= op;
		req_ch.block_number <= blk;
		req_ch.last_block   <= last;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (blk < DISK_SIZE)
			claimed[blk[5:0]] = 1'b1;
		sent++;
	endtask

	initial begin
		int                        k;
		int                        n;
		int                        target;
		int                        spoil_at;
		bit                        abandon;
		logic [iba_pkg::BLK_W-1:0] idx;
		logic [iba_pkg::BLK_W-1:0] blk;
		logic [iba_pkg::BLK_W-1:0] bad;
		arst_n              <= 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.opcode       <= iba_pkg::OP_START;
		req_ch.block_number <= '0;
		req_ch.last_block   <= 1'b0;
		claimed = '0;
		sent    = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(iba_pkg::OP_DATA, 7'd5, 1'b1);
		send_item(iba_pkg::OP_START, 7'd127, 1'b1);
		send_item(iba_pkg::OP_DATA, 7'd3, 1'b0);
		send_item(iba_pkg::OP_DATA, 7'd3, 1'b1);
		send_item(iba_pkg::OP_START, 7'd0, 1'b0);
		send_item(iba_pkg::OP_DATA, 7'd0, 1'b0);
		send_item(iba_pkg::OP_DATA, 7'd1, 1'b1);
		send_item(iba_pkg::OP_START, 7'd63, 1'b1);
		send_item(iba_pkg::OP_DATA, 7'd127, 1'b0);
		send_item(iba_pkg::OP_DATA, 7'd2, 1'b1);
		send_item(iba_pkg::OP_START, 7'd1, 1'b0);
		send_item(iba_pkg::OP_DATA, 7'd2, 1'b0);
		send_item(iba_pkg::OP_START, 7'd10, 1'b0);
		send_item(iba_pkg::OP_DATA, 7'd11, 1'b0);
		send_item(iba_pkg::OP_DATA, 7'd11, 1'b0);
		send_item(iba_pkg::OP_DATA, 7'd12, 1'b1);
		send_item(iba_pkg::OP_START, 7'd11, 1'b0);
		send_item(iba_pkg::OP_DATA, 7'd13, 1'b1);
		send_item(iba_pkg::OP_START, 7'd20, 1'b0);
		send_item(iba_pkg::OP_DATA, 7'd10, 1'b1);
		send_item(iba_pkg::OP_DATA, 7'd21, 1'b0);
		send_item(iba_pkg::OP_START, 7'd64, 1'b0);
		send_item(iba_pkg::OP_START, 7'd50, 1'b0);
		for (k = 0; k < 64; k++)
			send_item(iba_pkg::OP_DATA, 7'd51, k == 63);
		send_item(iba_pkg::OP_START, 7'd30, 1'b0);
		for (k = 0; k < 65; k++)
			send_item(iba_pkg::OP_DATA, 7'd31, 1'b0);
		send_item(iba_pkg::OP_DATA, 7'd32, 1'b1);
		send_item(iba_pkg::OP_START, 7'd40, 1'b0);
		send_item(iba_pkg::OP_DATA, 7'd64, 1'b1);
		send_item(iba_pkg::OP_DATA, 7'd41, 1'b1);

		target = 400;
		while (sent < target) begin
			if ($urandom_range(0, 9) < 7) begin
				n        = $urandom_range(1, 4);
				spoil_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n - 1) : -1;
				abandon  = ($urandom_range(0, 9) == 0);
				idx      = pick_free();
				send_item(iba_pkg::OP_START, idx, $urandom_range(0, 3) == 0);
				blk = pick_free();
				for (k = 0; k < n; k++) begin
					if (k > 0 && $urandom_range(0, 2) != 0)
						blk = pick_free();
					if (k == spoil_at) begin
						bad = $urandom_range(0, 1) ? idx
							: iba_pkg::BLK_W'($urandom_range(64, 127));
						send_item(iba_pkg::OP_DATA, bad, k == n - 1 && !abandon);
					end else begin
						send_item(iba_pkg::OP_DATA, blk, k == n - 1 && !abandon);
					end
				end
			end else begin
				send_item(iba_pkg::opcode_t'($urandom_range(0, 1)),
					iba_pkg::BLK_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
			end
		end

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (backlog != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0 && backlog == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		int gap;
		taken = 0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = ((taken / 37) % 3 == 1) ? 0 : $urandom_range(0, 10);
			if (taken == 60 || taken == 300)
				gap = 150;
			if (gap > 0) begin
				res_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
			taken++;
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("status: fail");
		$finish;
	end

endmodule
